[rtl/sfpa_pkg.sv]
`default_nettype none

package sfpa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ROWS_W   = 11;
    localparam int SUM_W    = SAMPLE_W + 3;
    localparam int ABS_W    = SUM_W - 1;
    localparam int PROD_W   = 2 * ABS_W;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd8;
    localparam logic [ROWS_W-1:0] ROWS_MAX   = 11'd1024;
    localparam logic [ROWS_W-1:0] ROWS_MIN   = 11'd1;
    localparam logic [ROWS_W-1:0] HALO_ROWS  = 11'd2;

    // divide by five: floor(x * ceil(2^20 / 5) / 2^20) is exact for x < 2^18
    localparam int               RECIP_SHIFT = 20;
    localparam logic [ABS_W-1:0] RECIP       = 18'd209716;
    localparam logic [ABS_W-1:0] ABS_MAX     = 18'd163840;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] top;
        logic signed [SAMPLE_W-1:0] centre;
        logic signed [SAMPLE_W-1:0] bottom;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       zero;
        logic                       last;
    } t_window;

endpackage

`default_nettype wire

[rtl/sfpa_if.sv]
`default_nettype none

interface sfpa_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sfpa_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sfpa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sfpa_pkg::SAMPLE_W-1:0] average;
    logic                                 last_in_strip;

    modport source (output valid, output average, output last_in_strip, input ready);
    modport sink   (input valid, input average, input last_in_strip, output ready);
endinterface

`default_nettype wire

[rtl/sfpa_ram.sv]
`default_nettype none

module sfpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/sfpa_window.sv]
`default_nettype none

module sfpa_window #(
    parameter int ROW_WIDTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sfpa_pkg::ROWS_W-1:0]   i_cfg_data,
    sfpa_in_if.sink                            i_smp,
    output logic                               o_win_valid,
    input  wire logic                          i_win_ready,
    output sfpa_pkg::t_window                  o_win
);

    localparam int                SW       = sfpa_pkg::SAMPLE_W;
    localparam int                RW       = sfpa_pkg::ROWS_W;
    localparam int                COL_W    = $clog2(ROW_WIDTH);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(ROW_WIDTH - 1);

    logic [RW-1:0]         r_rows;
    logic [COL_W-1:0]      r_col;
    logic [RW-1:0]         r_row;
    logic signed [SW-1:0]  r_left;
    logic                  r_win_valid;
    sfpa_pkg::t_window     r_win;

    logic [COL_W-1:0]      n_col;
    logic [RW-1:0]         n_row;
    logic signed [SW-1:0]  n_left;
    sfpa_pkg::t_window     n_win;

    logic                  accept;
    logic                  produce;
    logic                  end_row;
    logic                  end_strip;
    logic [RW-1:0]         eff_rows;
    logic [RW-1:0]         last_row;
    logic [COL_W-1:0]      addr_b;
    logic [2*SW-1:0]       a_q;
    logic [SW-1:0]         b_q;

    assign i_smp.ready = i_rst_n & (~r_win_valid | i_win_ready);
    assign accept      = i_smp.valid & i_smp.ready;

    always_comb begin
        if (r_rows == '0) begin
            eff_rows = sfpa_pkg::ROWS_MIN;
        end else if (r_rows > sfpa_pkg::ROWS_MAX) begin
            eff_rows = sfpa_pkg::ROWS_MAX;
        end else begin
            eff_rows = r_rows;
        end
    end

    assign last_row  = eff_rows + RW'(1);
    assign end_row   = (r_col == LAST_COL);
    assign end_strip = end_row && (r_row >= last_row);
    assign produce   = (r_row >= sfpa_pkg::HALO_ROWS);

    always_comb begin
        n_col  = end_row ? '0 : r_col + COL_W'(1);
        addr_b = (n_col == LAST_COL) ? '0 : n_col + COL_W'(1);
        n_left = end_row ? '0 : $signed(a_q[SW-1:0]);
        if (end_strip) begin
            n_row = '0;
        end else if (end_row) begin
            n_row = r_row + RW'(1);
        end else begin
            n_row = r_row;
        end
        n_win.top    = $signed(a_q[2*SW-1:SW]);
        n_win.centre = $signed(a_q[SW-1:0]);
        n_win.bottom = i_smp.sample;
        n_win.left   = r_left;
        n_win.right  = $signed(b_q);
        n_win.zero   = (r_col == '0) || end_row;
        n_win.last   = end_strip;
    end

    // entry holds {upper row, middle row}; reads run one column ahead
    sfpa_ram #(.WIDTH(2 * SW), .DEPTH(ROW_WIDTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata ({a_q[SW-1:0], i_smp.sample}),
        .i_re    (accept),
        .i_raddr (n_col),
        .o_rdata (a_q)
    );

    // middle row copy for the right neighbor
    sfpa_ram #(.WIDTH(SW), .DEPTH(ROW_WIDTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_smp.sample),
        .i_re    (accept),
        .i_raddr (addr_b),
        .o_rdata (b_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= sfpa_pkg::ROWS_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_win_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rows <= i_cfg_data;
            end
            if (accept) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_left      <= n_left;
                r_win_valid <= produce;
            end else if (i_win_ready) begin
                r_win_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_win <= n_win;
        end
    end

    assign o_win_valid = r_win_valid;
    assign o_win       = r_win;

`ifndef SYNTHESIS
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && end_row |=> r_col == '0)
        else $error("column did not wrap at row end");

    a_strip_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && end_strip |=> r_row == '0)
        else $error("row did not restart at strip end");

    a_halo_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !produce |=> !r_win_valid)
        else $error("halo row produced a window");
`endif

endmodule

`default_nettype wire

[rtl/sfpa_average.sv]
`default_nettype none

module sfpa_average (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_win_valid,
    output logic                    o_win_ready,
    input  wire sfpa_pkg::t_window  i_win,
    sfpa_out_if.source              o_avg
);

    localparam int SW     = sfpa_pkg::SAMPLE_W;
    localparam int SUM_W  = sfpa_pkg::SUM_W;
    localparam int ABS_W  = sfpa_pkg::ABS_W;
    localparam int PROD_W = sfpa_pkg::PROD_W;

    logic                  r_s2_valid;
    logic [ABS_W-1:0]      r_s2_abs;
    logic                  r_s2_neg;
    logic                  r_s2_zero;
    logic                  r_s2_last;
    logic                  r_o_valid;
    logic signed [SW-1:0]  r_o_avg;
    logic                  r_o_last;

    logic signed [SUM_W-1:0] sum;
    logic [ABS_W-1:0]        n_abs;
    logic [PROD_W-1:0]       prod;
    logic [SW-1:0]           quot;
    logic signed [SW-1:0]    n_avg;
    logic                    out_ready;
    logic                    s2_ready;

    assign out_ready   = ~r_o_valid | o_avg.ready;
    assign s2_ready    = ~r_s2_valid | out_ready;
    assign o_win_ready = s2_ready;

    always_comb begin
        sum = SUM_W'($signed(i_win.top)) + SUM_W'($signed(i_win.centre))
            + SUM_W'($signed(i_win.bottom)) + SUM_W'($signed(i_win.left))
            + SUM_W'($signed(i_win.right));
        n_abs = sum[SUM_W-1] ? ABS_W'(-sum) : ABS_W'(sum);
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    always_comb begin
        prod = PROD_W'(r_s2_abs) * PROD_W'(sfpa_pkg::RECIP);
        quot = prod[sfpa_pkg::RECIP_SHIFT +: SW];
        if (r_s2_zero) begin
            n_avg = '0;
        end else if (r_s2_neg) begin
            n_avg = $signed(-quot);
        end else begin
            n_avg = $signed(quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_win_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_win_valid && s2_ready) begin
            r_s2_abs  <= n_abs;
            r_s2_neg  <= sum[SUM_W-1];
            r_s2_zero <= i_win.zero;
            r_s2_last <= i_win.last;
        end
        if (r_s2_valid && out_ready) begin
            r_o_avg  <= n_avg;
            r_o_last <= r_s2_last;
        end
    end

    assign o_avg.valid         = r_o_valid;
    assign o_avg.average       = r_o_avg;
    assign o_avg.last_in_strip = r_o_last;

`ifndef SYNTHESIS
    a_abs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> r_s2_abs <= sfpa_pkg::ABS_MAX)
        else $error("sum magnitude out of range");

    a_last_is_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_last |-> r_s2_zero)
        else $error("strip end not on a boundary column");

    a_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && out_ready && r_s2_zero |=> r_o_valid && r_o_avg == '0)
        else $error("boundary column result not zero");
`endif

endmodule

`default_nettype wire

[rtl/stencil_five_point_average_int16.sv]
// Each result passes the window, sum and output registers after its bottom sample.
// Throughput: one sample per cycle unless the output stalls; the line buffers take
// one write and one read-ahead per transfer, so rows stream without gaps.
// The first two rows of a strip only fill the line buffers and give no result.
// Reset (i_rst_n low, synchronous) clears positions and handshakes, sets the row
// count to 8; line buffer contents are not cleared.
`default_nettype none

module stencil_five_point_average_int16 #(
    parameter int ROW_WIDTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sfpa_pkg::ROWS_W-1:0] i_cfg_data,
    sfpa_in_if.sink                          i_smp,
    sfpa_out_if.source                       o_avg
);

    logic              win_valid;
    logic              win_ready;
    sfpa_pkg::t_window win;

    sfpa_window #(.ROW_WIDTH(ROW_WIDTH)) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_smp       (i_smp),
        .o_win_valid (win_valid),
        .i_win_ready (win_ready),
        .o_win       (win)
    );

    sfpa_average u_average (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .o_win_ready (win_ready),
        .i_win       (win),
        .o_avg       (o_avg)
    );

endmodule

`default_nettype wire

[tb/tb_stencil_five_point_average_int16.sv]
`timescale 1ns / 1ps

module tb_stencil_five_point_average_int16;

    localparam int ROW_W        = 64;
    localparam int DIVISOR      = 5;
    localparam int ROWS_CAP     = 1024;
    localparam int AVG_MAX      = 32767;
    localparam int AVG_MIN      = -32768;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_WAIT   = 8;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int PRINT_CAP    = 40;

    typedef logic signed [sfpa_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample average;
        logic    last_in_strip;
    } t_stencil_out;

    typedef enum int {
        FILL_MIX,
        FILL_MAX,
        FILL_MIN
    } t_fill;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [sfpa_pkg::ROWS_W-1:0] i_cfg_data;

    sfpa_in_if  smp_if ();
    sfpa_out_if avg_if ();

    stencil_five_point_average_int16 #(
        .ROW_WIDTH (ROW_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if),
        .o_avg      (avg_if)
    );

    // stencil predictor state
    t_sample                     upper_row  [ROW_W];
    t_sample                     middle_row [ROW_W];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    int                          left_val;
    logic [sfpa_pkg::ROWS_W-1:0] strip_rows;

    t_stencil_out expected_avgs [$];
    t_stencil_out want;
    t_sample      pending_samples [$];

    // handshake bookkeeping
    bit          smp_fired;
    bit          avg_fired;
    bit          idling;
    int unsigned smp_gap;
    int unsigned avg_gap;
    int unsigned hold_left;
    int unsigned holds_asked;
    int unsigned holds_seen;
    logic        drv_valid;
    t_sample     drv_sample;

    int unsigned cycles;
    int unsigned errors;
    int unsigned samples_queued;
    int unsigned samples_taken;
    int unsigned avgs_checked;
    int unsigned strips_ended;
    int unsigned cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_gap();
        return idling ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic t_sample draw_sample(input t_fill fill);
        case (fill)
            FILL_MAX:  return t_sample'(AVG_MAX);
            FILL_MIN:  return t_sample'(AVG_MIN);
            default: begin
                case ($urandom_range(0, 7))
                    0:       return t_sample'(AVG_MAX);
                    1:       return t_sample'(AVG_MIN);
                    2:       return t_sample'($urandom_range(0, 16) - 8);
                    3:       return t_sample'($urandom_range(0, 4000) - 2000);
                    default: return t_sample'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic void stencil_step(input t_sample bottom);
        int           top;
        int           centre;
        int           right;
        int           total;
        int unsigned  last_row;
        t_stencil_out res;
        if (strip_rows == 0) begin
            last_row = 2;
        end else if (strip_rows > ROWS_CAP) begin
            last_row = ROWS_CAP + 1;
        end else begin
            last_row = strip_rows + 1;
        end
        top    = upper_row[col_pos];
        centre = middle_row[col_pos];
        right  = (col_pos + 1 < ROW_W) ? middle_row[col_pos + 1] : 0;
        if (row_pos >= 2) begin
            if (col_pos == 0 || col_pos == ROW_W - 1) begin
                total = 0;
            end else begin
                total = (centre + top + bottom + left_val + right) / DIVISOR;
                if (total > AVG_MAX) total = AVG_MAX;
                if (total < AVG_MIN) total = AVG_MIN;
            end
            res.average       = t_sample'(total);
            res.last_in_strip = (col_pos == ROW_W - 1) && (row_pos >= last_row);
            expected_avgs.push_back(res);
        end
        left_val            = centre;
        upper_row[col_pos]  = t_sample'(centre);
        middle_row[col_pos] = bottom;
        if (col_pos == ROW_W - 1) begin
            col_pos  = 0;
            left_val = 0;
            row_pos  = (row_pos >= last_row) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycles, what);
    endtask

    // monitor: transfers, prediction and checking at the rising edge
    always @(posedge i_clk) begin
        cycles++;
        smp_fired = i_rst_n && smp_if.valid && smp_if.ready;
        avg_fired = i_rst_n && avg_if.valid && avg_if.ready;
        if (!i_rst_n) begin
            col_pos    = 0;
            row_pos    = 0;
            left_val   = 0;
            strip_rows = sfpa_pkg::ROWS_RESET;
        end else begin
            if (smp_fired) begin
                samples_taken++;
                stencil_step(smp_if.sample);
            end
            if (i_cfg_we) strip_rows = i_cfg_data;
            if (avg_fired) begin
                if (expected_avgs.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer average=%0d last=%0b",
                                              avg_if.average, avg_if.last_in_strip));
                end else begin
                    want = expected_avgs.pop_front();
                    avgs_checked++;
                    if (want.last_in_strip) strips_ended++;
                    if (avg_if.average !== want.average)
                        report_mismatch($sformatf("average got %0d want %0d",
                                                  avg_if.average, want.average));
                    if (avg_if.last_in_strip !== want.last_in_strip)
                        report_mismatch($sformatf("last_in_strip got %0b want %0b",
                                                  avg_if.last_in_strip, want.last_in_strip));
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d averages outstanding",
                     cycles, expected_avgs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        drv_valid  = smp_if.valid;
        drv_sample = smp_if.sample;
        if (!i_rst_n) begin
            drv_valid = 1'b0;
        end else begin
            if (smp_fired) begin
                drv_valid = 1'b0;
                smp_gap   = draw_gap();
            end
            if (!drv_valid) begin
                if (smp_gap > 0) begin
                    smp_gap--;
                end else if (pending_samples.size() > 0) begin
                    drv_sample = pending_samples.pop_front();
                    drv_valid  = 1'b1;
                end
            end
        end
        smp_if.valid  <= drv_valid;
        smp_if.sample <= drv_sample;
    end

    // result sink with random and long stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            avg_if.ready <= 1'b0;
        end else begin
            if (avg_fired) avg_gap = draw_gap();
            if (hold_left == 0 && holds_seen != holds_asked) begin
                holds_seen++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                avg_if.ready <= 1'b0;
            end else if (avg_gap > 0) begin
                avg_gap--;
                avg_if.ready <= 1'b0;
            end else begin
                avg_if.ready <= 1'b1;
            end
        end
    end

    task automatic queue_samples(input int unsigned count, input t_fill fill);
        repeat (count) pending_samples.push_back(draw_sample(fill));
        samples_queued += count;
    endtask

    task automatic write_rows(input logic [sfpa_pkg::ROWS_W-1:0] count);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    task automatic wait_drained();
        int unsigned spin;
        spin = 0;
        do @(negedge i_clk); while (samples_taken != samples_queued);
        while (expected_avgs.size() > 0 && spin < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        avg_if.ready  = 1'b0;
        idling        = 1'b1;
        for (int i = 0; i < ROW_W; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one full strip at the reset row count, with a long output stall
        holds_asked++;
        queue_samples((sfpa_pkg::ROWS_RESET + sfpa_pkg::HALO_ROWS) * ROW_W, FILL_MIX);
        wait_drained();

        // row count zero acts as one: saturated strip, back to back
        idling = 1'b0;
        write_rows('0);
        queue_samples(3 * ROW_W, FILL_MAX);
        wait_drained();

        // oversized count, then shrink it while the strip is past the new last row
        idling = 1'b1;
        write_rows('1);
        holds_asked++;
        queue_samples(3 * ROW_W, FILL_MIN);
        wait_drained();
        write_rows(sfpa_pkg::ROWS_MIN);
        queue_samples(ROW_W, FILL_MIN);
        wait_drained();

        if (expected_avgs.size() > 0)
            report_mismatch($sformatf("%0d averages never arrived", expected_avgs.size()));
        $display("Sent %0d samples, checked %0d averages over %0d completed strips",
                 samples_taken, avgs_checked, strips_ended);
        $display("Row count written %0d times, %0d long output stalls, %0d cycles",
                 cfg_writes, holds_asked, cycles);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
